// File: rtl/ias_pkg.sv
// shared types and constants of the indexed array store
// operation and status codes, channel words, controller/datapath command and status
// no dependencies
package ias_pkg;

   localparam int OP_W     = 3;
   localparam int POS_W    = 8;
   localparam int VAL_W    = 32;
   localparam int CNT_OUT_W = 9;
   localparam int ST_W     = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_READ   = 3'd2;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd4;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd5;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd6;

   // status codes
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } ias_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [POS_W-1:0]        found_index;
      logic                    found;
      logic [CNT_OUT_W-1:0]    count;
      logic [ST_W-1:0]         status;
      logic                    is_empty;
   } ias_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic issue;
      logic tail;
      logic out_load;
   } ias_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic can_issue;
      logic walk_done;
   } ias_sts_type;

endpackage

// File: rtl/ias_stream_if.sv
// valid/ready channel interfaces for request and response words
// depends on ias_pkg
interface ias_req_if;
   logic                  valid;
   logic                  ready;
   ias_pkg::ias_req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ias_rsp_if;
   logic                  valid;
   logic                  ready;
   ias_pkg::ias_rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/ias_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ias_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ias_datapath.sv
// datapath: fill count, request registers, walk pointers, element ram and response word
// depends on ias_pkg and ias_ram
module ias_datapath #(
   parameter int DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ias_pkg::ias_cmd_type  cmd,
   output ias_pkg::ias_sts_type  sts,
   input  ias_pkg::ias_req_type  req_word,
   output ias_pkg::ias_rsp_type  rsp_word
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > ias_pkg::CNT_OUT_W) ? CNT_W : ias_pkg::CNT_OUT_W;
   localparam logic [CMP_W-1:0] DEPTH_EXT = CMP_W'(DEPTH);

   typedef enum logic [2:0] {
      M_NONE, M_INSERT, M_POP, M_READ, M_DELETE, M_REMOVE, M_FIND
   } mode_type;

   mode_type                          mode_ff, mode_in;
   logic [CMP_W-1:0]                  pos_ff, pos_in;
   logic signed [ias_pkg::VAL_W-1:0]  val_ff, val_in;
   logic [ias_pkg::ST_W-1:0]          status_ff, status_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CMP_W-1:0]                  rd_ptr_ff, rd_ptr_in;
   logic [CMP_W-1:0]                  rem_ff, rem_in;
   logic [CMP_W-1:0]                  w_ff, w_in;
   logic                              stage_vld_ff, stage_vld_in;
   logic [CMP_W-1:0]                  stage_idx_ff, stage_idx_in;
   logic                              found_ff, found_in;
   logic [CMP_W-1:0]                  fidx_ff, fidx_in;
   logic signed [ias_pkg::VAL_W-1:0]  rd_val_ff, rd_val_in;
   ias_pkg::ias_rsp_type              rsp_ff, rsp_in;

   logic [CMP_W-1:0]                  req_pos;
   logic [CMP_W-1:0]                  cnt_ext;
   logic                              wr_en;
   logic [CMP_W-1:0]                  wr_addr;
   logic signed [ias_pkg::VAL_W-1:0]  wr_data;
   logic [ias_pkg::VAL_W-1:0]         ram_rd_data;
   logic signed [ias_pkg::VAL_W-1:0]  stage_data;

   assign req_pos    = CMP_W'(req_word.position);
   assign cnt_ext    = CMP_W'(count_ff);
   assign stage_data = ram_rd_data;

   ias_ram #(
      .WIDTH (ias_pkg::VAL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.issue),
      .rd_addr (rd_ptr_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      rem_in       = rem_ff;
      w_in         = w_ff;
      stage_vld_in = cmd.issue;
      stage_idx_in = rd_ptr_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      rd_val_in    = rd_val_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = val_ff;

      // decode and range checks at acceptance
      if (cmd.load) begin
         val_in    = req_word.value;
         pos_in    = req_pos;
         status_in = ias_pkg::ST_OK;
         mode_in   = M_NONE;
         rem_in    = '0;
         rd_ptr_in = '0;
         w_in      = '0;
         found_in  = 1'b0;
         fidx_in   = '0;
         rd_val_in = '0;
         case (req_word.operation)
            ias_pkg::OP_PUSH: begin
               // push is an insert at the end
               pos_in = cnt_ext;
               if (cnt_ext >= DEPTH_EXT) begin
                  status_in = ias_pkg::ST_FULL;
               end else begin
                  mode_in = M_INSERT;
               end
            end
            ias_pkg::OP_INSERT: begin
               if (req_pos > cnt_ext) begin
                  status_in = ias_pkg::ST_RANGE;
               end else if (cnt_ext >= DEPTH_EXT) begin
                  status_in = ias_pkg::ST_FULL;
               end else begin
                  mode_in   = M_INSERT;
                  rem_in    = cnt_ext - req_pos;
                  rd_ptr_in = cnt_ext - 1'b1;
               end
            end
            ias_pkg::OP_POP: begin
               if (cnt_ext == '0) begin
                  status_in = ias_pkg::ST_EMPTY;
               end else begin
                  mode_in   = M_POP;
                  rem_in    = CMP_W'(1);
                  rd_ptr_in = cnt_ext - 1'b1;
               end
            end
            ias_pkg::OP_READ: begin
               if (req_pos >= cnt_ext) begin
                  status_in = ias_pkg::ST_RANGE;
               end else begin
                  mode_in   = M_READ;
                  rem_in    = CMP_W'(1);
                  rd_ptr_in = req_pos;
               end
            end
            ias_pkg::OP_DELETE: begin
               if (req_pos >= cnt_ext) begin
                  status_in = ias_pkg::ST_RANGE;
               end else begin
                  mode_in   = M_DELETE;
                  rem_in    = cnt_ext - req_pos - 1'b1;
                  rd_ptr_in = req_pos + 1'b1;
               end
            end
            ias_pkg::OP_REMOVE: begin
               mode_in = M_REMOVE;
               rem_in  = cnt_ext;
            end
            ias_pkg::OP_FIND: begin
               mode_in = M_FIND;
               rem_in  = cnt_ext;
            end
            default: begin
               mode_in = M_NONE;
            end
         endcase
      end

      // read issue, one word per cycle
      if (cmd.issue) begin
         rem_in = rem_ff - 1'b1;
         if (mode_ff == M_INSERT) begin
            rd_ptr_in = rd_ptr_ff - 1'b1;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end

      // read data returns in the cycle after issue
      if (stage_vld_ff) begin
         case (mode_ff)
            M_INSERT: begin
               wr_en   = 1'b1;
               wr_addr = stage_idx_ff + 1'b1;
               wr_data = stage_data;
            end
            M_DELETE: begin
               wr_en   = 1'b1;
               wr_addr = stage_idx_ff - 1'b1;
               wr_data = stage_data;
            end
            M_REMOVE: begin
               if (stage_data != val_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = w_ff;
                  wr_data = stage_data;
                  w_in    = w_ff + 1'b1;
               end
            end
            M_FIND: begin
               if (!found_ff && stage_data == val_ff) begin
                  found_in = 1'b1;
                  fidx_in  = stage_idx_ff;
               end
            end
            M_POP, M_READ: begin
               rd_val_in = stage_data;
            end
            default: begin
            end
         endcase
      end

      // final write and count update
      if (cmd.tail) begin
         case (mode_ff)
            M_INSERT: begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = val_ff;
               count_in = CNT_W'(cnt_ext + 1'b1);
            end
            M_POP, M_DELETE: begin
               count_in = CNT_W'(cnt_ext - 1'b1);
            end
            M_REMOVE: begin
               count_in = CNT_W'(w_ff);
            end
            default: begin
            end
         endcase
      end

      if (cmd.out_load) begin
         rsp_in.read_value  = rd_val_ff;
         rsp_in.found_index = fidx_ff[ias_pkg::POS_W-1:0];
         rsp_in.found       = found_ff;
         rsp_in.count       = cnt_ext[ias_pkg::CNT_OUT_W-1:0];
         rsp_in.status      = status_ff;
         rsp_in.is_empty    = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_NONE;
         count_ff     <= '0;
         rem_ff       <= '0;
         stage_vld_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         stage_vld_ff <= stage_vld_in;
         found_ff     <= found_in;
      end
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      status_ff    <= status_in;
      rd_ptr_ff    <= rd_ptr_in;
      w_ff         <= w_in;
      stage_idx_ff <= stage_idx_in;
      fidx_ff      <= fidx_in;
      rd_val_ff    <= rd_val_in;
      rsp_ff       <= rsp_in;
   end

   assign sts.can_issue = (rem_ff != '0) && !found_ff;
   assign sts.walk_done = ((rem_ff == '0) || found_ff) && !stage_vld_ff;
   assign rsp_word      = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_tail_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.tail |-> !stage_vld_ff)
      else $error("final write collides with walk write");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.tail && mode_ff == M_INSERT |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("insert did not grow the count");
`endif

endmodule

// File: rtl/ias_ctrl.sv
// controller state machine: accept, walk, final update, response hand-off
// depends on ias_pkg
module ias_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ias_pkg::ias_sts_type  sts,
   output ias_pkg::ias_cmd_type  cmd
);

   typedef enum logic [1:0] {IDLE, WALK, TAIL, DONE} state_type;

   state_type state_ff, state_in;
   logic      rsp_vld_ff, rsp_vld_in;

   always_comb begin
      cmd.load     = (state_ff == IDLE) && req_valid;
      cmd.issue    = (state_ff == WALK) && sts.can_issue;
      cmd.tail     = (state_ff == TAIL);
      cmd.out_load = (state_ff == DONE) && (!rsp_vld_ff || rsp_ready);

      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               state_in = WALK;
            end
         end
         WALK: begin
            if (sts.walk_done) begin
               state_in = TAIL;
            end
         end
         TAIL: begin
            state_in = DONE;
         end
         DONE: begin
            if (cmd.out_load) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      if (cmd.out_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_vld_ff;

`ifndef SYNTH
   a_accept_starts_walk: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == WALK)
      else $error("accepted word did not start a walk");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_vld_ff || rsp_ready)
      else $error("response overwritten before taken");

   a_out_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_vld_ff && state_ff == IDLE)
      else $error("loaded response not presented");
`endif

endmodule

// File: rtl/indexed_array_store_unit.sv
// indexed array store: a request is answered after a walk over n stored words; n is 1
// for pop and read, count-pos for insert, count-pos-1 for delete, count for remove-all and
// a find miss, hit index+2 (at most count) for a find hit; a new request is taken only
// after the response of the last one is loaded, and the single ram read port walks one
// word a cycle
// synchronous reset empties the store (count zero); ram contents are not cleared
module indexed_array_store_unit #(
   parameter int DEPTH = 256
) (
   input  logic      clock,
   input  logic      reset,
   ias_req_if.sink   req_chan,
   ias_rsp_if.source rsp_chan
);

   // command and status between controller and datapath
   ias_pkg::ias_cmd_type cmd;
   ias_pkg::ias_sts_type sts;

   // controller: accepts a word only when idle, hands the response to the output register
   ias_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: element ram, fill count, walk pointers and the response register
   ias_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_word (req_chan.payload),
      .rsp_word (rsp_chan.payload)
   );

endmodule
